@@ src/esm_pkg.sv @@
`timescale 1ns / 1ps
// esm_pkg: operation codes, sequencer states and the control/status structs
// shared by the controller and the datapath of the element stiffness matvec block
package esm_pkg;

	localparam int OPCODE_W = 3;

	localparam logic [OPCODE_W-1:0] OP_WRITE_U  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_WRITE_F  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_READ_F   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_SET_SLOT = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_COEF     = 3'd4;

	localparam logic [4:0] NODES_RESET = 5'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP,
		ST_MAP,
		ST_MUL,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic capture;
		logic wr_u;
		logic wr_f;
		logic rd_f;
		logic wr_slot;
		logic rd_slot;
		logic rd_map;
		logic mul;
		logic acc;
	} esm_cmd_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic                dof_ok;
		logic                slot_ok;
		logic                coef_ok;
		logic                map_ok;
	} esm_status_t;

endpackage

@@ src/esm_ctrl.sv @@
`timescale 1ns / 1ps
// esm_ctrl: sequencer for the element stiffness matvec block
// depends on esm_pkg; drives esm_datapath through esm_cmd_t and reads esm_status_t
module esm_ctrl
	import esm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  esm_status_t status,
	output esm_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_next  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_next = ST_IDLE;
				unique case (status.op)
					OP_WRITE_U:  cmd.wr_u = status.dof_ok;
					OP_WRITE_F:  cmd.wr_f = status.dof_ok;
					OP_READ_F: begin
						cmd.rd_f   = status.dof_ok;
						state_next = ST_RESP;
					end
					OP_SET_SLOT: cmd.wr_slot = status.slot_ok;
					OP_COEF: begin
						// look up both slots only when row and column are inside the element
						if (status.coef_ok) begin
							cmd.rd_slot = 1'b1;
							state_next  = ST_MAP;
						end
					end
					default: state_next = ST_IDLE;
				endcase
			end
			ST_RESP: state_next = ST_IDLE;
			ST_MAP: begin
				if (status.map_ok) begin
					cmd.rd_map = 1'b1;
					state_next = ST_MUL;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc    = 1'b1;
				state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

endmodule

@@ src/esm_datapath.sv @@
`timescale 1ns / 1ps
// esm_datapath: displacement and force stores, slot table, multiply and saturating accumulate
// depends on esm_pkg; commanded by esm_ctrl
module esm_datapath
	import esm_pkg::*;
#(
	parameter int NODE_COUNT        = 1024,
	parameter int MAX_ELEMENT_NODES = 20,
	parameter int FRACTION_BITS     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          operation,
	input  logic [11:0]         global_dof,
	input  logic [4:0]          local_slot,
	input  logic [9:0]          mesh_node,
	input  logic [5:0]          matrix_row,
	input  logic [5:0]          matrix_col,
	input  logic signed [31:0]  data_value,
	input  logic                cfg_write_enable,
	input  logic [4:0]          cfg_write_data,
	input  esm_cmd_t            cmd,
	output esm_status_t         status,
	output logic signed [31:0]  force_value,
	output logic                saturation_seen
);

	localparam int DOF_COUNT = 3 * NODE_COUNT;
	localparam int ADDR_W    = $clog2(DOF_COUNT);
	localparam int SLOT_W    = $clog2(MAX_ELEMENT_NODES);

	// stores
	logic signed [31:0] u_mem [DOF_COUNT];
	logic signed [31:0] f_mem [DOF_COUNT];
	logic [9:0]         slot_mem [MAX_ELEMENT_NODES];

	// captured word
	logic [2:0]         op_q;
	logic [11:0]        dof_q;
	logic [4:0]         slot_q;
	logic [9:0]         node_q;
	logic [5:0]         row_q;
	logic [5:0]         col_q;
	logic signed [31:0] val_q;

	logic [4:0]         nodes_q;
	logic               sat_q;

	logic [9:0]         row_node_q;
	logic [9:0]         col_node_q;
	logic [ADDR_W-1:0]  grow_q;
	logic signed [31:0] u_rd_q;
	logic signed [31:0] f_rd_q;
	logic signed [63:0] prod_q;

	// decode
	logic [31:0]        dof32;
	logic [ADDR_W-1:0]  dof_addr;
	logic [4:0]         nodes_eff;
	logic [6:0]         limit;
	logic [12:0]        row_mul;
	logic [12:0]        col_mul;
	logic [4:0]         row_slot;
	logic [4:0]         col_slot;
	logic [1:0]         row_comp;
	logic [1:0]         col_comp;
	logic [11:0]        grow;
	logic [11:0]        gcol;
	logic [31:0]        grow32;
	logic [31:0]        gcol32;

	// accumulate
	logic signed [63:0] prod_shift;
	logic signed [63:0] sum;
	logic signed [31:0] sum_sat;
	logic               sum_clip;

	logic               f_we;
	logic [ADDR_W-1:0]  f_waddr;
	logic signed [31:0] f_wdata;
	logic               f_re;
	logic [ADDR_W-1:0]  f_raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= NODES_RESET;
			sat_q   <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				nodes_q <= cfg_write_data;
			end
			if (cmd.acc && sum_clip) begin
				sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			dof_q  <= global_dof;
			slot_q <= local_slot;
			node_q <= mesh_node;
			row_q  <= matrix_row;
			col_q  <= matrix_col;
			val_q  <= data_value;
		end
		if (cmd.rd_map) begin
			grow_q <= grow32[ADDR_W-1:0];
		end
		if (cmd.mul) begin
			prod_q <= 64'(val_q) * 64'(u_rd_q);
		end
	end

	assign dof32    = 32'(dof_q);
	assign dof_addr = dof32[ADDR_W-1:0];

	assign nodes_eff = (32'(nodes_q) < 32'(MAX_ELEMENT_NODES)) ? nodes_q : 5'(MAX_ELEMENT_NODES);
	assign limit     = 7'({nodes_eff, 1'b0}) + 7'(nodes_eff);

	// divide by three through the reciprocal 43/128, exact for values below 128
	assign row_mul  = 13'(row_q) * 13'd43;
	assign col_mul  = 13'(col_q) * 13'd43;
	assign row_slot = row_mul[11:7];
	assign col_slot = col_mul[11:7];
	assign row_comp = 2'(row_q - 6'({row_slot, 1'b0}) - 6'(row_slot));
	assign col_comp = 2'(col_q - 6'({col_slot, 1'b0}) - 6'(col_slot));

	assign grow   = 12'({row_node_q, 1'b0}) + 12'(row_node_q) + 12'(row_comp);
	assign gcol   = 12'({col_node_q, 1'b0}) + 12'(col_node_q) + 12'(col_comp);
	assign grow32 = 32'(grow);
	assign gcol32 = 32'(gcol);

	assign status.op      = op_q;
	assign status.dof_ok  = dof32 < 32'(DOF_COUNT);
	assign status.slot_ok = 32'(slot_q) < 32'(MAX_ELEMENT_NODES);
	assign status.coef_ok = (7'(row_q) < limit) && (7'(col_q) < limit);
	assign status.map_ok  = (grow32 < 32'(DOF_COUNT)) && (gcol32 < 32'(DOF_COUNT));

	// slot table, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_slot) begin
			slot_mem[slot_q[SLOT_W-1:0]] <= node_q;
		end
		if (cmd.rd_slot) begin
			row_node_q <= slot_mem[row_slot[SLOT_W-1:0]];
			col_node_q <= slot_mem[col_slot[SLOT_W-1:0]];
		end
	end

	// displacement store
	always_ff @(posedge clk) begin
		if (cmd.wr_u) begin
			u_mem[dof_addr] <= val_q;
		end
		if (cmd.rd_map) begin
			u_rd_q <= u_mem[gcol32[ADDR_W-1:0]];
		end
	end

	// floor shift of the product, then clip the sum to 32 bits
	assign prod_shift = prod_q >>> FRACTION_BITS;
	assign sum        = prod_shift + 64'(f_rd_q);

	always_comb begin
		sum_clip = 1'b0;
		sum_sat  = sum[31:0];
		priority if (sum > 64'sd2147483647) begin
			sum_clip = 1'b1;
			sum_sat  = 32'sh7FFFFFFF;
		end else if (sum < -64'sd2147483648) begin
			sum_clip = 1'b1;
			sum_sat  = 32'sh80000000;
		end else begin
			sum_clip = 1'b0;
		end
	end

	// force store: one write port shared by host writes and accumulation
	assign f_we    = cmd.wr_f | cmd.acc;
	assign f_waddr = cmd.acc ? grow_q : dof_addr;
	assign f_wdata = cmd.acc ? sum_sat : val_q;
	assign f_re    = cmd.rd_f | cmd.rd_map;
	assign f_raddr = cmd.rd_map ? grow32[ADDR_W-1:0] : dof_addr;

	always_ff @(posedge clk) begin
		if (f_we) begin
			f_mem[f_waddr] <= f_wdata;
		end
		if (f_re) begin
			f_rd_q <= f_mem[f_raddr];
		end
	end

	assign force_value     = status.dof_ok ? f_rd_q : 32'sd0;
	assign saturation_seen = sat_q;

	a_sat_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sat_q) |-> $past(cmd.acc))
		else $error("saturation flag set outside an accumulate");

	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(sat_q))
		else $error("saturation flag cleared");

endmodule

@@ src/element_stiffness_matvec_scatter.sv @@
`timescale 1ns / 1ps
// element_stiffness_matvec_scatter: top level, controller plus datapath
// depends on esm_pkg, esm_ctrl and esm_datapath
//
// A word is taken when start is high and busy is low; busy then stays high until the
// block can take the next word. Writes of u or f, slot table loads and unknown
// operations pass through the execute state only. A force read also passes through
// the response state: the entry comes out on force_value with saturation_seen during
// the one cycle that done is high, and must be taken then, as there is no way to
// hold it. A stiffness coefficient runs slot table lookup, gather of u and f from
// their stores, multiply and saturating write-back; it stops before the lookup if its
// row or column lies outside the element and after the lookup if a mapped dof lies
// outside the stores. The sequencer handles one word at a time, so a coefficient
// finishes before the next word is taken. The stores and slot table hold no reset value.
module element_stiffness_matvec_scatter
	import esm_pkg::*;
#(
	parameter int NODE_COUNT        = 1024,
	parameter int MAX_ELEMENT_NODES = 20,
	parameter int FRACTION_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [2:0]         operation,
	input  logic [11:0]        global_dof,
	input  logic [4:0]         local_slot,
	input  logic [9:0]         mesh_node,
	input  logic [5:0]         matrix_row,
	input  logic [5:0]         matrix_col,
	input  logic signed [31:0] data_value,
	input  logic               cfg_write_enable,
	input  logic [4:0]         cfg_write_data,
	output logic signed [31:0] force_value,
	output logic               saturation_seen
);

	esm_cmd_t    cmd;
	esm_status_t status;

	esm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	esm_datapath #(
		.NODE_COUNT        (NODE_COUNT),
		.MAX_ELEMENT_NODES (MAX_ELEMENT_NODES),
		.FRACTION_BITS     (FRACTION_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.operation        (operation),
		.global_dof       (global_dof),
		.local_slot       (local_slot),
		.mesh_node        (mesh_node),
		.matrix_row       (matrix_row),
		.matrix_col       (matrix_col),
		.data_value       (data_value),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.cmd              (cmd),
		.status           (status),
		.force_value      (force_value),
		.saturation_seen  (saturation_seen)
	);

	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_READ_F) |-> ##2 done)
		else $error("force read gave no result word");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> $past(cmd.mul))
		else $error("accumulate without a product");

endmodule
